// ----- rtl/sta_pkg.sv -----
// Shared constants, codes and types for the slot table allocator.
package sta_pkg;

    localparam int DEPTH     = 64;
    localparam int SLOT_W    = $clog2(DEPTH);
    localparam int CNT_W     = 7;
    localparam int IN_IDX_W  = 10;
    localparam int VAL_W     = 64;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 3;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_ZERO  = 3'd4;

    // command group from controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } sta_cmd_t;

endpackage

// ----- rtl/sta_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sta_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sta_ctrl.sv -----
// Controller state machine: accept, execute, strobe the result.
module sta_ctrl
    import sta_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output sta_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;
    logic done_next;

    // decode commands from the current state
    always_comb
    begin
        cmd.capture = start && (state_reg == S_IDLE);
        cmd.execute = (state_reg == S_EXEC);
        done_next   = cmd.execute;
        unique case (state_reg)
            S_IDLE:  state_next = cmd.capture ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // hold state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;

    // a transfer in always leads to exactly one busy cycle, then a strobe
    a_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> busy)
        else $error("accepted item did not enter execute");
    a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && done))
        else $error("execute did not end with a result strobe");
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding execute");

endmodule

// ----- rtl/sta_datapath.sv -----
// Datapath: occupancy bits, free slot search, count, entry RAM and result registers.
module sta_datapath
    import sta_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  sta_cmd_t            cmd,
    input  logic                cfg_wr_en,
    input  logic [CNT_W-1:0]    cfg_wr_data,
    input  logic [MODE_W-1:0]   mode,
    input  logic [IN_IDX_W-1:0] slot_index,
    input  logic [VAL_W-1:0]    entry_value,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot_out,
    output logic [VAL_W-1:0]    read_value,
    output logic [CNT_W-1:0]    occupied_count
);

    logic [MODE_W-1:0]   mode_reg;
    logic [IN_IDX_W-1:0] idx_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [CNT_W-1:0]    size_reg;
    logic [DEPTH-1:0]    occ_reg;
    logic [DEPTH-1:0]    occ_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [VAL_W-1:0]    read_reg;
    logic [VAL_W-1:0]    read_next;

    logic [CNT_W-1:0]    eff_size;
    logic [DEPTH-1:0]    in_use;
    logic [DEPTH-1:0]    free_mask;
    logic                found;
    logic [SLOT_W-1:0]   free_idx;
    logic                in_range;
    logic [SLOT_W-1:0]   tgt;
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [VAL_W-1:0]    ram_wdata;
    logic [VAL_W-1:0]    ram_rdata;

    // entry store; read address follows the slot index at the transfer edge
    sta_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (slot_index[SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    // saturate size and build the in-use mask
    always_comb
    begin
        eff_size = (size_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : size_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            in_use[i] = (CNT_W'(i) < eff_size);
        end
        free_mask = ~occ_reg & in_use;
    end

    // priority encode the lowest free slot
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (free_mask[i])
            begin
                found    = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign tgt      = idx_reg[SLOT_W-1:0];
    assign in_range = (idx_reg < {{(IN_IDX_W-CNT_W){1'b0}}, eff_size});

    // execute the operation
    always_comb
    begin
        status_next = STATUS_OK;
        slot_next   = tgt;
        read_next   = '0;
        occ_next    = occ_reg;
        count_next  = count_reg;
        ram_we      = 1'b0;
        ram_waddr   = tgt;
        ram_wdata   = val_reg;
        unique case (mode_reg)
            MODE_APPEND:
            begin
                slot_next = '0;
                if (val_reg == '0)
                begin
                    status_next = STATUS_ZERO;
                end
                else if (count_reg >= eff_size || !found)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    ram_we             = 1'b1;
                    ram_waddr          = free_idx;
                    occ_next[free_idx] = 1'b1;
                    count_next         = count_reg + CNT_W'(1);
                    slot_next          = free_idx;
                end
            end
            MODE_SET:
            begin
                if (!in_range)
                begin
                    status_next = STATUS_RANGE;
                end
                else
                begin
                    ram_we = 1'b1;
                    if (val_reg == '0)
                    begin
                        if (occ_reg[tgt])
                        begin
                            occ_next[tgt] = 1'b0;
                            count_next    = count_reg - CNT_W'(1);
                        end
                    end
                    else if (!occ_reg[tgt])
                    begin
                        occ_next[tgt] = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
            end
            MODE_GET:
            begin
                if (!in_range)
                begin
                    status_next = STATUS_RANGE;
                end
                else if (occ_reg[tgt])
                begin
                    read_next = ram_rdata;
                end
                else
                begin
                    status_next = STATUS_EMPTY;
                end
            end
            MODE_DELETE:
            begin
                if (!in_range)
                begin
                    status_next = STATUS_RANGE;
                end
                else if (!occ_reg[tgt])
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    ram_we        = 1'b1;
                    ram_wdata     = '0;
                    occ_next[tgt] = 1'b0;
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
        ram_we = ram_we && cmd.execute;
    end

    // capture the input transfer and register the result of execute
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            idx_reg  <= slot_index;
            val_reg  <= entry_value;
        end
        if (cmd.execute)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            read_reg   <= read_next;
        end
    end

    // advance occupancy, count and size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            count_reg <= '0;
            size_reg  <= CNT_W'(DEPTH);
        end
        else
        begin
            if (cmd.execute)
            begin
                occ_reg   <= occ_next;
                count_reg <= count_next;
            end
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
        end
    end

    assign status         = status_reg;
    assign slot_out       = slot_reg;
    assign read_value     = read_reg;
    assign occupied_count = count_reg;

    // the running count always matches the occupancy bits
    a_count_bits: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'($countones(occ_reg)) == count_reg)
        else $error("occupied count out of step with occupancy bits");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("occupied count above depth");
    a_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.execute |=> $stable(occ_reg))
        else $error("occupancy changed outside execute");

endmodule

// ----- rtl/slot_table_allocator.sv -----
// Top level of the slot table allocator: controller plus datapath.
// An item is taken at the edge where start is high and busy is low; busy is then high
// for one cycle while the entry RAM's registered read completes and the op executes.
// The result shows on done in the cycle after busy; no new item is taken while busy
// is high, as the op waits for the registered read of the entry RAM.
// Reset clears the occupancy bits and count and sets the size to 64; the entry RAM
// is not cleared. The receiver cannot stall: done is a single-cycle strobe.
module slot_table_allocator
    import sta_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MODE_W-1:0]   mode,
    input  logic [IN_IDX_W-1:0] slot_index,
    input  logic [VAL_W-1:0]    entry_value,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot_out,
    output logic [VAL_W-1:0]    read_value,
    output logic [CNT_W-1:0]    occupied_count,
    input  logic                cfg_wr_en,
    input  logic [CNT_W-1:0]    cfg_wr_data
);

    sta_cmd_t cmd;

    // sequence each item
    sta_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // table state and result
    sta_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mode           (mode),
        .slot_index     (slot_index),
        .entry_value    (entry_value),
        .status         (status),
        .slot_out       (slot_out),
        .read_value     (read_value),
        .occupied_count (occupied_count)
    );

endmodule

// ----- tb/slot_table_allocator_tb.sv -----
// Self-checking testbench for the slot table allocator: directed table, then random traffic.
module slot_table_allocator_tb;
    import sta_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int N_ROWS      = 29;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [VAL_W-1:0]    rdval;
        logic [CNT_W-1:0]    count;
    } table_result_t;

    // one row of the directed table: an operation or a size write
    typedef struct packed {
        logic                size_write;
        logic [MODE_W-1:0]   mode;
        logic [IN_IDX_W-1:0] idx;
        logic [VAL_W-1:0]    val;
        logic                typed;
        table_result_t       want;
    } stim_row_t;

    localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};
    localparam logic [VAL_W-1:0] TOP_BIT  = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] ALT_A    = {(VAL_W/2){2'b10}};
    localparam logic [VAL_W-1:0] PATTERN  = 64'h0123_4567_89AB_CDEF;

    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{1'b0, MODE_GET,    10'd0,    64'd0,    1'b1, '{STATUS_EMPTY, 6'd0,  64'd0,    7'd0}},
        '{1'b0, MODE_DELETE, 10'd0,    64'd0,    1'b1, '{STATUS_EMPTY, 6'd0,  64'd0,    7'd0}},
        '{1'b0, MODE_APPEND, 10'd0,    64'd0,    1'b1, '{STATUS_ZERO,  6'd0,  64'd0,    7'd0}},
        '{1'b0, MODE_APPEND, 10'd17,   ALL_ONES, 1'b1, '{STATUS_OK,    6'd0,  64'd0,    7'd1}},
        '{1'b0, MODE_APPEND, 10'd1023, 64'd1,    1'b1, '{STATUS_OK,    6'd1,  64'd0,    7'd2}},
        '{1'b0, MODE_GET,    10'd0,    64'd0,    1'b1, '{STATUS_OK,    6'd0,  ALL_ONES, 7'd2}},
        '{1'b0, MODE_GET,    10'd1023, 64'd0,    1'b1, '{STATUS_RANGE, 6'd63, 64'd0,    7'd2}},
        '{1'b0, MODE_SET,    10'd64,   64'd5,    1'b1, '{STATUS_RANGE, 6'd0,  64'd0,    7'd2}},
        '{1'b0, MODE_DELETE, 10'd0,    64'd0,    1'b1, '{STATUS_OK,    6'd0,  64'd0,    7'd1}},
        '{1'b0, MODE_APPEND, 10'd0,    TOP_BIT,  1'b1, '{STATUS_OK,    6'd0,  64'd0,    7'd2}},
        '{1'b0, MODE_SET,    10'd63,   ALT_A,    1'b1, '{STATUS_OK,    6'd63, 64'd0,    7'd3}},
        '{1'b0, MODE_GET,    10'd63,   64'd0,    1'b1, '{STATUS_OK,    6'd63, ALT_A,    7'd3}},
        '{1'b0, MODE_SET,    10'd62,   64'd0,    1'b1, '{STATUS_OK,    6'd62, 64'd0,    7'd3}},
        '{1'b0, MODE_SET,    10'd63,   64'd0,    1'b1, '{STATUS_OK,    6'd63, 64'd0,    7'd2}},
        '{1'b0, MODE_DELETE, 10'd1,    64'd0,    1'b1, '{STATUS_OK,    6'd1,  64'd0,    7'd1}},
        '{1'b0, MODE_GET,    10'd1,    64'd0,    1'b1, '{STATUS_EMPTY, 6'd1,  64'd0,    7'd1}},
        '{1'b0, MODE_DELETE, 10'h2A5,  64'd0,    1'b1, '{STATUS_RANGE, 6'd37, 64'd0,    7'd1}},
        '{1'b0, MODE_SET,    10'd40,   PATTERN,  1'b0, '0},
        '{1'b1, MODE_APPEND, 10'd0,    64'd2,    1'b0, '0},
        '{1'b0, MODE_APPEND, 10'd0,    64'd7,    1'b0, '0},
        '{1'b0, MODE_APPEND, 10'd0,    64'd9,    1'b1, '{STATUS_FULL,  6'd0,  64'd0,    7'd2}},
        '{1'b0, MODE_GET,    10'd2,    64'd0,    1'b1, '{STATUS_RANGE, 6'd2,  64'd0,    7'd2}},
        '{1'b1, MODE_APPEND, 10'd0,    64'd0,    1'b0, '0},
        '{1'b0, MODE_APPEND, 10'd0,    64'd3,    1'b1, '{STATUS_FULL,  6'd0,  64'd0,    7'd2}},
        '{1'b0, MODE_GET,    10'd0,    64'd0,    1'b1, '{STATUS_RANGE, 6'd0,  64'd0,    7'd2}},
        '{1'b1, MODE_APPEND, 10'd0,    64'd127,  1'b0, '0},
        '{1'b0, MODE_GET,    10'd40,   64'd0,    1'b0, '0},
        '{1'b0, MODE_GET,    10'd1,    64'd0,    1'b0, '0},
        '{1'b0, MODE_DELETE, 10'd40,   64'd0,    1'b0, '0}
    };

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                start          = 1'b0;
    logic [MODE_W-1:0]   mode           = MODE_APPEND;
    logic [IN_IDX_W-1:0] slot_index     = '0;
    logic [VAL_W-1:0]    entry_value    = '0;
    logic                cfg_wr_en      = 1'b0;
    logic [CNT_W-1:0]    cfg_wr_data    = '0;
    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [VAL_W-1:0]    read_value;
    logic [CNT_W-1:0]    occupied_count;

    // predictor copy of the table and the size register
    logic [VAL_W-1:0]    shadow_store [DEPTH];
    bit                  shadow_occ   [DEPTH];
    int unsigned         shadow_total;
    logic [CNT_W-1:0]    shadow_size;

    table_result_t       pending_results [$];
    int unsigned         mismatch_count = 0;
    int unsigned         cycle_count    = 0;

    slot_table_allocator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .slot_index     (slot_index),
        .entry_value    (entry_value),
        .done           (done),
        .status         (status),
        .slot_out       (slot_out),
        .read_value     (read_value),
        .occupied_count (occupied_count),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int unsigned usable_slots();
        return (shadow_size > DEPTH) ? DEPTH : shadow_size;
    endfunction

    // apply one operation to the shadow table and return the result it produces
    function automatic table_result_t apply_table_op(input logic [MODE_W-1:0] op,
                                                     input logic [IN_IDX_W-1:0] idx,
                                                     input logic [VAL_W-1:0] val);
        table_result_t res;
        int unsigned   lim;
        int            free_slot;
        lim       = usable_slots();
        free_slot = -1;
        res.status = STATUS_OK;
        res.slot   = idx[SLOT_W-1:0];
        res.rdval  = '0;
        if (op == MODE_APPEND)
        begin
            res.slot = '0;
            if (val == '0)
                res.status = STATUS_ZERO;
            else if (shadow_total >= lim)
                res.status = STATUS_FULL;
            else
            begin
                for (int i = lim - 1; i >= 0; i--)
                    if (!shadow_occ[i])
                        free_slot = i;
                if (free_slot < 0)
                    res.status = STATUS_FULL;
                else
                begin
                    shadow_store[free_slot] = val;
                    shadow_occ[free_slot]   = 1'b1;
                    shadow_total++;
                    res.slot = free_slot[SLOT_W-1:0];
                end
            end
        end
        else if (idx >= lim)
            res.status = STATUS_RANGE;
        else if (op == MODE_SET)
        begin
            if (val == '0 && shadow_occ[idx])
                shadow_total--;
            else if (val != '0 && !shadow_occ[idx])
                shadow_total++;
            shadow_occ[idx]   = (val != '0);
            shadow_store[idx] = val;
        end
        else if (op == MODE_GET)
        begin
            if (shadow_occ[idx])
                res.rdval = shadow_store[idx];
            else
                res.status = STATUS_EMPTY;
        end
        else
        begin
            if (!shadow_occ[idx])
                res.status = STATUS_EMPTY;
            else
            begin
                shadow_occ[idx]   = 1'b0;
                shadow_store[idx] = '0;
                shadow_total--;
            end
        end
        res.count = shadow_total[CNT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // check each result strobe against the oldest expectation
    always @(negedge clk)
    begin
        table_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", {61'd0, status}, '0);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", VAL_W'(status), VAL_W'(want.status));
                if (slot_out !== want.slot)
                    report_mismatch("slot_out", VAL_W'(slot_out), VAL_W'(want.slot));
                if (read_value !== want.rdval)
                    report_mismatch("read_value", read_value, want.rdval);
                if (occupied_count !== want.count)
                    report_mismatch("occupied_count", VAL_W'(occupied_count),
                                    VAL_W'(want.count));
            end
        end
    end

    // hold the operation until it transfers, then queue its expected result
    task automatic issue_op(input logic [MODE_W-1:0] op, input logic [IN_IDX_W-1:0] idx,
                            input logic [VAL_W-1:0] val, input bit typed,
                            input table_result_t typed_want);
        table_result_t want;
        bit            held;
        start       <= 1'b1;
        mode        <= op;
        slot_index  <= idx;
        entry_value <= val;
        do
        begin
            @(negedge clk);
            held = busy;
            @(posedge clk);
        end while (held);
        want = apply_table_op(op, idx, val);
        pending_results.push_back(typed ? typed_want : want);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // half back to back (all when steady), most others short gaps, a few long ones
    function automatic int unsigned pick_gap(input bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 30);
    endfunction

    // drop start and wait out every outstanding result
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_size(input logic [CNT_W-1:0] size);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_size = size;
    endtask

    initial
    begin
        logic [CNT_W-1:0]    phase_sizes [10];
        int unsigned         phase_len;
        int unsigned         r;
        int unsigned         lim;
        logic [MODE_W-1:0]   op;
        logic [IN_IDX_W-1:0] idx;
        logic [VAL_W-1:0]    val;
        bit                  steady;

        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_store[i] = '0;
            shadow_occ[i]   = 1'b0;
        end
        shadow_total = 0;
        shadow_size  = CNT_W'(64);

        // hold reset, then release
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].size_write)
                write_size(DIRECTED_ROWS[i].val[CNT_W-1:0]);
            else
            begin
                issue_op(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].val,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
                idle_sender(pick_gap(1'b0));
            end
        end

        // random phases, each under its own table size
        phase_sizes = '{7'd64, 7'd1, 7'd127, 7'd8, 7'd0, 7'd2, 7'd64, 7'd33, 7'd5, 7'd64};
        phase_sizes[5] = CNT_W'($urandom_range(1, 64));
        foreach (phase_sizes[p])
        begin
            write_size(phase_sizes[p]);
            lim       = usable_slots();
            phase_len = (lim == 0) ? 20 : 70;
            steady    = (p == 3 || p == 7);
            for (int n = 0; n < phase_len; n++)
            begin
                r  = $urandom_range(0, 99);
                op = (r < 35) ? MODE_APPEND : (r < 55) ? MODE_SET :
                     (r < 78) ? MODE_GET : MODE_DELETE;
                r   = $urandom_range(0, 99);
                val = (r < 8) ? '0 : (r < 14) ? ALL_ONES : {$urandom, $urandom};
                r   = $urandom_range(0, 99);
                if (r < 80 && lim > 0)
                    idx = IN_IDX_W'($urandom_range(0, lim - 1));
                else
                    idx = IN_IDX_W'($urandom_range(0, 1023));
                issue_op(op, idx, val, 1'b0, '0);
                if ($urandom_range(0, 59) == 0)
                    drain_results();
                else
                    idle_sender(pick_gap(steady));
            end
        end

        // let the last results arrive
        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
